FILE: rtl/core/swt_pkg.sv
// Shared types and constants of the software timer table.
package swt_pkg;

    localparam int CMD_W    = 3;
    localparam int IDX_W    = 3;
    localparam int PERIOD_W = 16;
    localparam int MASK_W   = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_SET_EN  = 3'd2,
        CMD_SET_PER = 3'd3,
        CMD_SERVICE = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    // Write controls broadcast from the top level to every cell.
    typedef struct packed {
        logic                add;
        logic                set_en;
        logic                set_per;
        logic [IDX_W-1:0]    index;
        logic                enable;
        logic [PERIOD_W-1:0] period;
    } cell_ctl_t;

endpackage

FILE: rtl/core/swt_cell.sv
// One timer entry of the chain: holds its state and checks expiry when the scan token arrives.
module swt_cell #(
    parameter int CELL_ID   = 0,
    parameter int TICK_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  swt_pkg::cell_ctl_t   ctl,
    input  logic [TICK_BITS-1:0] tick,
    input  logic                 token_in,
    output logic                 token_out,
    output logic                 hit
);

    localparam int CMP_W = (TICK_BITS > swt_pkg::PERIOD_W) ? TICK_BITS : swt_pkg::PERIOD_W;

    logic                         en_reg, en_next;
    logic [TICK_BITS-1:0]         ref_reg, ref_next;
    logic [swt_pkg::PERIOD_W-1:0] per_reg, per_next;
    logic                         tok_reg;
    logic [TICK_BITS-1:0]         elapsed;
    logic                         sel;

    assign elapsed = tick - ref_reg;
    assign sel     = (32'(ctl.index) == CELL_ID);
    assign hit     = token_in && en_reg && (CMP_W'(elapsed) > CMP_W'(per_reg));

    always_comb
    begin
        en_next  = en_reg;
        ref_next = ref_reg;
        per_next = per_reg;
        if (hit)
        begin
            // A one-shot timer turns itself off; a periodic one restarts.
            ref_next = tick;
            if (per_reg == '0)
            begin
                en_next = 1'b0;
            end
        end
        else if (sel && ctl.add)
        begin
            en_next  = ctl.enable;
            ref_next = '0;
            per_next = ctl.period;
        end
        else if (sel && ctl.set_en)
        begin
            en_next  = ctl.enable;
            ref_next = tick;
        end
        else if (sel && ctl.set_per)
        begin
            per_next = ctl.period;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg  <= 1'b0;
            ref_reg <= '0;
            per_reg <= '0;
            tok_reg <= 1'b0;
        end
        else
        begin
            en_reg  <= en_next;
            ref_reg <= ref_next;
            per_reg <= per_next;
            tok_reg <= token_in;
        end
    end

    assign token_out = tok_reg;

endmodule

FILE: rtl/core/software_timer_table.sv
// Top level of the software timer table: command decode, tick counter and the cell chain.
//
// Usage: a command word is taken at a rising edge where start is high and busy is
// low. Its fields are command, timer_index, enable_value and period_value.
// Tick, add timer, set enable and set period complete in that same edge; busy
// stays low and another word may follow in the very next cycle. Unused command
// codes and indexes beyond the table change nothing.
// A service word raises busy and launches a token down the row of NUM_TIMERS
// cells, one cell per cycle; each cell checks and updates its own timer when
// the token passes. The result word (expired_mask) appears with the done
// strobe once the token leaves the last cell; done is high for exactly one
// cycle and expired_mask holds until the next service. busy drops at the edge
// that ends the done cycle, and the next word can be taken once busy is low.
// The token walking the chain sets how long a service keeps busy high.
// Every service returns one result word, even when its mask is zero; timers
// beyond the eighth are serviced but have no mask bit.
// The receiver cannot stall: done lasts one cycle and must be taken then.
// Reset (rst_n low) clears the tick count and every timer's enable, reference
// and period, and leaves the block idle.
module software_timer_table #(
    parameter int NUM_TIMERS = 8,
    parameter int TICK_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [swt_pkg::CMD_W-1:0]    command,
    input  logic [swt_pkg::IDX_W-1:0]    timer_index,
    input  logic                         enable_value,
    input  logic [swt_pkg::PERIOD_W-1:0] period_value,
    output logic                         done,
    output logic [swt_pkg::MASK_W-1:0]   expired_mask
);

    swt_pkg::state_t             state_reg, state_next;
    logic [TICK_BITS-1:0]        tick_reg, tick_next;
    logic                        launch_reg;
    logic [swt_pkg::MASK_W-1:0]  mask_reg, mask_next;
    logic                        accept;
    swt_pkg::cell_ctl_t          ctl;
    logic [NUM_TIMERS:0]         tok;
    logic [NUM_TIMERS-1:0]       hit;
    logic [swt_pkg::MASK_W-1:0]  hit_mask;

    assign busy   = (state_reg == swt_pkg::ST_SCAN);
    assign accept = start && !busy;

    // Write controls are only live on the edge a word is taken.
    always_comb
    begin
        ctl.add     = 1'b0;
        ctl.set_en  = 1'b0;
        ctl.set_per = 1'b0;
        ctl.index   = timer_index;
        ctl.enable  = enable_value;
        ctl.period  = period_value;
        if (accept)
        begin
            case (command)
                swt_pkg::CMD_ADD:     ctl.add     = 1'b1;
                swt_pkg::CMD_SET_EN:  ctl.set_en  = 1'b1;
                swt_pkg::CMD_SET_PER: ctl.set_per = 1'b1;
                default:              ;
            endcase
        end
    end

    assign tok[0] = launch_reg;

    for (genvar i = 0; i < NUM_TIMERS; i++)
    begin : g_cell
        swt_cell #(
            .CELL_ID   (i),
            .TICK_BITS (TICK_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .tick      (tick_reg),
            .token_in  (tok[i]),
            .token_out (tok[i+1]),
            .hit       (hit[i])
        );
    end

    // Only the first eight timers own a bit of the mask.
    for (genvar b = 0; b < swt_pkg::MASK_W; b++)
    begin : g_mask
        if (b < NUM_TIMERS)
        begin : g_on
            assign hit_mask[b] = hit[b];
        end
        else
        begin : g_off
            assign hit_mask[b] = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        tick_next  = tick_reg;
        mask_next  = mask_reg | hit_mask;
        case (state_reg)
            swt_pkg::ST_IDLE:
            begin
                if (accept && command == swt_pkg::CMD_TICK)
                begin
                    tick_next = tick_reg + 1'b1;
                end
                if (accept && command == swt_pkg::CMD_SERVICE)
                begin
                    state_next = swt_pkg::ST_SCAN;
                    mask_next  = '0;
                end
            end
            swt_pkg::ST_SCAN:
            begin
                if (done)
                begin
                    state_next = swt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= swt_pkg::ST_IDLE;
            tick_reg   <= '0;
            launch_reg <= 1'b0;
            mask_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            tick_reg   <= tick_next;
            launch_reg <= accept && (command == swt_pkg::CMD_SERVICE);
            mask_reg   <= mask_next;
        end
    end

    // The token leaving the last cell marks a finished pass.
    assign done         = tok[NUM_TIMERS];
    assign expired_mask = mask_reg;

endmodule

FILE: rtl/core/swt_checker.sv
// Port-level checker of the software timer table and its bind statement.
module swt_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [swt_pkg::CMD_W-1:0] command,
    input logic                      done
);

    // A result word only comes out of a service in progress.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    a_service_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == swt_pkg::CMD_SERVICE) |=> busy)
        else $error("service word did not raise busy");

    a_other_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command != swt_pkg::CMD_SERVICE) |=> !busy)
        else $error("single-cycle command raised busy");

    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy && !done))
        else $error("busy or done held after the result word");

endmodule

bind software_timer_table swt_checker u_swt_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .command (command),
    .done    (done)
);

FILE: dv/tb.sv
// Self-checking testbench for the software timer table: directed table, random words, predictor.
`timescale 1ns / 100ps

module tb;

    localparam int NUM_TIMERS = 8;
    localparam int TICK_BITS  = 16;

    // Codes 5 to 7 are not decoded by the block; they must be swallowed silently.
    localparam logic [swt_pkg::CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [swt_pkg::CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    // One command word as it appears on the input ports.
    typedef struct packed {
        logic [swt_pkg::CMD_W-1:0]    command;
        logic [swt_pkg::IDX_W-1:0]    index;
        logic                         enable;
        logic [swt_pkg::PERIOD_W-1:0] period;
    } cmd_word_t;

    // A directed row carries a hand-written mask only where the answer is obvious;
    // otherwise the predictor supplies the expected mask.
    typedef struct packed {
        cmd_word_t                  word;
        logic                       has_mask;
        logic [swt_pkg::MASK_W-1:0] mask;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 24;

    // The opening rows walk through reset state, unused codes, one-shot and periodic
    // expiry, a period that can never be exceeded, disabled timers and set period.
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{'{swt_pkg::CMD_SERVICE, 3'd0, 1'b0, 16'h0000}, 1'b1, 8'h00},
        '{'{CMD_SPARE_FIRST,      3'd7, 1'b1, 16'hFFFF}, 1'b0, 8'h00},
        '{'{CMD_SPARE_FIRST + 3'd1, 3'd0, 1'b0, 16'h0000}, 1'b0, 8'h00},
        '{'{CMD_SPARE_LAST,       3'd5, 1'b1, 16'hAAAA}, 1'b0, 8'h00},
        '{'{swt_pkg::CMD_ADD,     3'd0, 1'b1, 16'h0000}, 1'b0, 8'h00},
        '{'{swt_pkg::CMD_TICK,    3'd0, 1'b0, 16'h0000}, 1'b0, 8'h00},
        '{'{swt_pkg::CMD_SERVICE, 3'd0, 1'b0, 16'h0000}, 1'b1, 8'h01},
        '{'{swt_pkg::CMD_SERVICE, 3'd0, 1'b0, 16'h0000}, 1'b1, 8'h00},
        '{'{swt_pkg::CMD_ADD,     3'd7, 1'b1, 16'hFFFF}, 1'b0, 8'h00},
        '{'{swt_pkg::CMD_ADD,     3'd3, 1'b1, 16'h0002}, 1'b0, 8'h00},
        '{'{swt_pkg::CMD_TICK,    3'd0, 1'b0, 16'h0000}, 1'b0, 8'h00},
        '{'{swt_pkg::CMD_TICK,    3'd0, 1'b0, 16'h0000}, 1'b0, 8'h00},
        '{'{swt_pkg::CMD_TICK,    3'd0, 1'b0, 16'h0000}, 1'b0, 8'h00},
        '{'{swt_pkg::CMD_SERVICE, 3'd0, 1'b0, 16'h0000}, 1'b1, 8'h08},
        '{'{swt_pkg::CMD_SET_EN,  3'd5, 1'b1, 16'h0000}, 1'b0, 8'h00},
        '{'{swt_pkg::CMD_SET_PER, 3'd3, 1'b0, 16'h0000}, 1'b0, 8'h00},
        '{'{swt_pkg::CMD_TICK,    3'd0, 1'b0, 16'h0000}, 1'b0, 8'h00},
        '{'{swt_pkg::CMD_SERVICE, 3'd0, 1'b0, 16'h0000}, 1'b1, 8'h28},
        '{'{swt_pkg::CMD_SET_EN,  3'd7, 1'b0, 16'h5555}, 1'b0, 8'h00},
        '{'{swt_pkg::CMD_ADD,     3'd2, 1'b0, 16'h0000}, 1'b0, 8'h00},
        '{'{swt_pkg::CMD_SET_PER, 3'd1, 1'b1, 16'hFFFF}, 1'b0, 8'h00},
        '{'{swt_pkg::CMD_ADD,     3'd6, 1'b1, 16'h8000}, 1'b0, 8'h00},
        '{'{swt_pkg::CMD_TICK,    3'd0, 1'b0, 16'h0000}, 1'b0, 8'h00},
        '{'{swt_pkg::CMD_SERVICE, 3'd0, 1'b0, 16'h0000}, 1'b0, 8'h00}
    };

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [swt_pkg::CMD_W-1:0]    command;
    logic [swt_pkg::IDX_W-1:0]    timer_index;
    logic                         enable_value;
    logic [swt_pkg::PERIOD_W-1:0] period_value;
    logic                         done;
    logic [swt_pkg::MASK_W-1:0]   expired_mask;

    // Shadow copy of the timer table, kept in step with every accepted word.
    logic [TICK_BITS-1:0]         tick_now;
    logic                         timer_on     [NUM_TIMERS];
    logic [TICK_BITS-1:0]         start_tick   [NUM_TIMERS];
    logic [swt_pkg::PERIOD_W-1:0] timer_period [NUM_TIMERS];

    // Masks still owed by the block, oldest first.
    logic [swt_pkg::MASK_W-1:0] pending_masks [$];

    int  error_count  = 0;
    int  words_taken  = 0;
    int  masks_seen   = 0;
    int  expiry_total = 0;
    int  tick_wraps   = 0;
    bit  idle_enabled = 1'b1;

    software_timer_table #(
        .NUM_TIMERS (NUM_TIMERS),
        .TICK_BITS  (TICK_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .timer_index  (timer_index),
        .enable_value (enable_value),
        .period_value (period_value),
        .done         (done),
        .expired_mask (expired_mask)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        error_count++;
    endtask

    // One service pass over the shadow table. A timer fires when its elapsed time,
    // taken modulo the tick width, is strictly above its period. A firing timer
    // reloads its start tick; a one-shot timer also switches itself off.
    function automatic logic [swt_pkg::MASK_W-1:0] service_pass();
        logic [swt_pkg::MASK_W-1:0] mask;
        logic [TICK_BITS-1:0]       elapsed;
        mask = '0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            elapsed = tick_now - start_tick[i];
            if (timer_on[i] && elapsed > timer_period[i])
            begin
                if (i < swt_pkg::MASK_W)
                    mask[i] = 1'b1;
                start_tick[i] = tick_now;
                if (timer_period[i] == '0)
                    timer_on[i] = 1'b0;
            end
        end
        return mask;
    endfunction

    // Applies one accepted word to the shadow table. Returns 1 when the word owes a
    // result, with the predicted mask in mask.
    function automatic bit predict_word(input cmd_word_t w,
                                        output logic [swt_pkg::MASK_W-1:0] mask);
        bit in_table;
        in_table = (w.index < NUM_TIMERS);
        mask     = '0;
        case (w.command)
            swt_pkg::CMD_TICK:
            begin
                tick_now = tick_now + 1'b1;
                if (tick_now == '0)
                    tick_wraps++;
            end
            swt_pkg::CMD_ADD:
            begin
                if (in_table)
                begin
                    timer_on[w.index]     = w.enable;
                    start_tick[w.index]   = '0;
                    timer_period[w.index] = w.period;
                end
            end
            swt_pkg::CMD_SET_EN:
            begin
                if (in_table)
                begin
                    timer_on[w.index]   = w.enable;
                    start_tick[w.index] = tick_now;
                end
            end
            swt_pkg::CMD_SET_PER:
            begin
                if (in_table)
                    timer_period[w.index] = w.period;
            end
            swt_pkg::CMD_SERVICE:
            begin
                mask = service_pass();
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Presents a word, optionally after random idle cycles, and holds it until the
    // block takes it (start high, busy low at a rising edge). The expectation is
    // queued at that same edge, well before done can come back.
    task automatic issue_word(input cmd_word_t w, input bit has_mask,
                              input logic [swt_pkg::MASK_W-1:0] typed_mask);
        logic [swt_pkg::MASK_W-1:0] predicted;
        bit                         owes_result;
        while (idle_enabled && $urandom_range(99) < 32)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        command      <= w.command;
        timer_index  <= w.index;
        enable_value <= w.enable;
        period_value <= w.period;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_taken++;
        owes_result = predict_word(w, predicted);
        if (owes_result)
            pending_masks.push_back(has_mask ? typed_mask : predicted);
    endtask

    // Half the periods are small so that timers fire often, with some full-range
    // values, the two largest values, and values near the tick count so that the
    // strictly-greater boundary is hit for timers started at tick zero.
    function automatic logic [swt_pkg::PERIOD_W-1:0] pick_period();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return swt_pkg::PERIOD_W'($urandom_range(12));
        else if (r < 65)
            return swt_pkg::PERIOD_W'($urandom);
        else if (r < 75)
            return $urandom_range(1) ? 16'hFFFF : 16'hFFFE;
        else
            return swt_pkg::PERIOD_W'(tick_now + swt_pkg::PERIOD_W'($urandom_range(6))
                                      - swt_pkg::PERIOD_W'(3));
    endfunction

    function automatic cmd_word_t random_word();
        cmd_word_t w;
        int        r;
        w.index  = swt_pkg::IDX_W'($urandom_range(NUM_TIMERS - 1));
        w.enable = 1'($urandom_range(1));
        w.period = swt_pkg::PERIOD_W'($urandom);
        r = $urandom_range(99);
        if (r < 38)
            w.command = swt_pkg::CMD_TICK;
        else if (r < 62)
            w.command = swt_pkg::CMD_SERVICE;
        else if (r < 72)
        begin
            w.command = swt_pkg::CMD_ADD;
            w.enable  = ($urandom_range(99) < 80);
            w.period  = pick_period();
        end
        else if (r < 82)
        begin
            w.command = swt_pkg::CMD_SET_EN;
            w.enable  = ($urandom_range(99) < 70);
        end
        else if (r < 92)
        begin
            w.command = swt_pkg::CMD_SET_PER;
            w.period  = pick_period();
        end
        else
            w.command = swt_pkg::CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
        return w;
    endfunction

    // Result checker: done is a one-cycle strobe that cannot be held off, so every
    // rising edge with done high is one result word to compare against the oldest
    // expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_masks.size() == 0)
                flag_mismatch($sformatf("unexpected result word, expired_mask=%02h",
                                        expired_mask));
            else
            begin
                if (expired_mask !== pending_masks[0])
                    flag_mismatch($sformatf("expired_mask=%02h, expected %02h",
                                            expired_mask, pending_masks[0]));
                masks_seen++;
                expiry_total += $countones(pending_masks[0]);
                void'(pending_masks.pop_front());
            end
        end
    end

    // Stimulus: reset, the directed table, then random words with one stretch of
    // steady back-to-back traffic, then drain.
    initial
    begin
        cmd_word_t w;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        command      <= swt_pkg::CMD_TICK;
        timer_index  <= '0;
        enable_value <= 1'b0;
        period_value <= '0;
        tick_now     = '0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            timer_on[i]     = 1'b0;
            start_tick[i]   = '0;
            timer_period[i] = '0;
        end
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
            issue_word(DIRECTED[r].word, DIRECTED[r].has_mask, DIRECTED[r].mask);

        for (int n = 0; n < 800; n++)
        begin
            idle_enabled = !(n >= 250 && n < 450);
            w = random_word();
            issue_word(w, 1'b0, '0);
        end
        start <= 1'b0;

        while (pending_masks.size() != 0)
            @(posedge clk);
        repeat (NUM_TIMERS + 4)
            @(posedge clk);

        $display("Run covered %0d command words and %0d service results (%0d expiries),",
                 words_taken, masks_seen, expiry_total);
        $display("with the tick counter wrapping %0d time(s).", tick_wraps);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Safety net against a hung handshake or a missing result word.
    initial
    begin
        #10_000_000;
        $display("Timeout: %0d result word(s) still outstanding.", pending_masks.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/swt_pkg.sv
rtl/core/swt_cell.sv
rtl/core/software_timer_table.sv
rtl/core/swt_checker.sv
dv/tb.sv
